### design/point_heading_and_distance_defines.svh
// assertion helpers for the point heading and distance checker
`ifndef POINT_HEADING_AND_DISTANCE_DEFINES_SVH
`define POINT_HEADING_AND_DISTANCE_DEFINES_SVH

// plain property, sampled on clk, off while rst_n is low
`define PTHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent implies consequent in the same cycle
`define PTHD_ASSERT_IMP(lbl, ante, cons, msg) \
  `PTHD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### design/pthd_pkg.sv
package pthd_pkg;

  localparam int GUARD_BITS = 8;
  localparam int Z_W        = 34;
  localparam int HEAD_W     = 16;
  localparam int DIST_W     = 17;

  typedef logic signed [Z_W-1:0]    ang_t;
  typedef logic signed [HEAD_W-1:0] head_t;
  typedef logic [DIST_W-1:0]        dist_t;

  localparam ang_t  PI_Q30      = 34'sd3373259426;
  localparam ang_t  HEAD_ROUND  = 34'sd65536;
  localparam head_t HEAD_MIN    = -16'sd25736;
  localparam head_t HEAD_MAX    = 16'sd25735;
  localparam head_t HALF_PI_OUT = 16'sd12868;
  localparam logic [15:0] GAIN_Q16 = 16'd39797;
  localparam dist_t DIST_MAX    = 17'h1FFFF;

  // atan(2^-i) in radians times 2^30
  localparam ang_t ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  // side band that travels with each transaction down the pipe
  typedef struct packed {
    logic  valid;
    logic  special;   // axis-aligned or zero vector, result known up front
    head_t heading;
    dist_t dist_val;
    logic  dy_pos;
    logic  dy_neg;
  } pthd_ctl_t;

endpackage

### design/pthd_prep.sv
module pthd_prep #(
  parameter int CW = 16,
  parameter int XW = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  logic signed [CW-1:0]     start_x,
  input  logic signed [CW-1:0]     start_y,
  input  logic signed [CW-1:0]     end_x,
  input  logic signed [CW-1:0]     end_y,
  output pthd_pkg::pthd_ctl_t      ctl_o,
  output logic signed [XW-1:0]     x_o,
  output logic signed [XW-1:0]     y_o,
  output pthd_pkg::ang_t           z_o
);
  import pthd_pkg::*;

  localparam int MW = (CW + 1 > DIST_W) ? CW + 1 : DIST_W;

  logic signed [CW:0]    dx, dy;
  logic signed [XW-1:0]  dxe, dye;
  logic                  dx_neg, dy_pos, dy_neg, dx_zero, dy_zero;
  logic [CW:0]           mag;
  logic [MW-1:0]         mag_w;
  pthd_ctl_t             ctl_nxt, ctl_r;
  logic signed [XW-1:0]  x_nxt, y_nxt, x_r, y_r;
  ang_t                  z_nxt, z_r;

  assign dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
  assign dy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
  assign dxe = {{(XW-CW-1){dx[CW]}}, dx};
  assign dye = {{(XW-CW-1){dy[CW]}}, dy};

  assign dx_neg  = dx[CW];
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dy_neg  = dy[CW];
  assign dy_pos  = !dy_neg && !dy_zero;

  always_comb begin
    // fold into the right half plane
    x_nxt = (dx_neg ? -dxe : dxe) <<< GUARD_BITS;
    y_nxt = (dx_neg ? -dye : dye) <<< GUARD_BITS;
    if (dx_neg) begin
      z_nxt = dy_pos ? PI_Q30 : -PI_Q30;
    end else begin
      z_nxt = '0;
    end

    if (dy_zero) begin
      mag = dx_neg ? -dx : dx;
    end else begin
      mag = dy_neg ? -dy : dy;
    end
    mag_w = MW'(mag);

    ctl_nxt.valid    = acc;
    ctl_nxt.special  = dy_zero || dx_zero;
    ctl_nxt.dy_pos   = dy_pos;
    ctl_nxt.dy_neg   = dy_neg;
    ctl_nxt.dist_val = (mag_w > MW'(DIST_MAX)) ? DIST_MAX : mag_w[DIST_W-1:0];
    if (dy_zero) begin
      ctl_nxt.heading = dx_neg ? HEAD_MIN : '0;
    end else begin
      ctl_nxt.heading = dy_pos ? HALF_PI_OUT : -HALF_PI_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

### design/pthd_cell.sv
module pthd_cell #(
  parameter int STAGE = 0,
  parameter int XW    = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pthd_pkg::pthd_ctl_t  ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  pthd_pkg::ang_t       z_i,
  output pthd_pkg::pthd_ctl_t  ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output pthd_pkg::ang_t       z_o
);
  import pthd_pkg::*;

  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt, x_r, y_r;
  ang_t                 z_nxt, z_r;
  pthd_ctl_t            ctl_r;

  // arithmetic shift floors, as required
  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_Q30[STAGE];
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_Q30[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

### design/pthd_post.sv
module pthd_post #(
  parameter int XW = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pthd_pkg::pthd_ctl_t  ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  pthd_pkg::ang_t       z_i,
  output logic                 valid_o,
  output pthd_pkg::head_t      heading_o,
  output pthd_pkg::dist_t      dist_o
);
  import pthd_pkg::*;

  localparam int PW = XW - 1 + 16;
  localparam int DW = PW + 1 - 24;
  localparam int SW = (DW > DIST_W) ? DW : DIST_W;

  ang_t            zr;
  head_t           head_nxt, head_r, head_out_r;
  logic [XW-2:0]   xc;
  logic [PW-1:0]   prod_nxt, prod_r;
  logic [PW:0]     rsum;
  logic [SW-1:0]   dfull;
  dist_t           dist_nxt, dist_out_r;
  pthd_ctl_t       ctl_r;
  logic            valid_out_r;

  // stage a: heading round and clamp (or the special heading), gain multiply
  always_comb begin
    zr = (z_i + HEAD_ROUND) >>> 17;
    if (zr < ang_t'(HEAD_MIN)) begin
      head_nxt = HEAD_MIN;
    end else if (zr > ang_t'(HEAD_MAX)) begin
      head_nxt = HEAD_MAX;
    end else begin
      head_nxt = zr[HEAD_W-1:0];
    end
    if (ctl_i.dy_pos && head_nxt[HEAD_W-1]) head_nxt = '0;
    if (ctl_i.dy_neg && !head_nxt[HEAD_W-1] && head_nxt != '0) head_nxt = '0;
    if (ctl_i.special) head_nxt = ctl_i.heading;

    xc       = x_i[XW-1] ? '0 : x_i[XW-2:0];
    prod_nxt = PW'(xc) * PW'(GAIN_Q16);
  end

  // stage b: distance round and saturate, or pass the special distance
  always_comb begin
    rsum  = {1'b0, prod_r} + (PW+1)'(1 << (15 + GUARD_BITS));
    dfull = SW'(rsum[PW:24]);
    if (ctl_r.special) begin
      dist_nxt = ctl_r.dist_val;
    end else if (dfull > SW'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = dfull[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      valid_out_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_i;
      valid_out_r <= ctl_r.valid;
    end
    head_r      <= head_nxt;
    prod_r      <= prod_nxt;
    head_out_r  <= head_r;
    dist_out_r  <= dist_nxt;
  end

  assign valid_o   = valid_out_r;
  assign heading_o = head_out_r;
  assign dist_o    = dist_out_r;

endmodule

### design/point_heading_and_distance.sv
// channel   direction  handshake              payload
// input     in         start, busy            in_start_x, in_start_y, in_end_x, in_end_y
// result    out        out_valid (strobe)     out_heading, out_distance
//
// one transaction accepted per cycle; busy is low whenever rst_n is high
// stages in order: a fold stage, one cordic cell per iteration, then a gain
// multiply stage and a rounding stage
// reset is synchronous and empties the pipe; transactions in flight are dropped
// the receiver cannot stall, each result shows for one cycle on out_valid
module point_heading_and_distance #(
  parameter int ITERATIONS  = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                          out_valid,
  output pthd_pkg::head_t               out_heading,
  output pthd_pkg::dist_t               out_distance
);
  import pthd_pkg::*;

  localparam int XW = COORD_WIDTH + 12;

  pthd_ctl_t            ctl_w [ITERATIONS+1];
  logic signed [XW-1:0] x_w   [ITERATIONS+1];
  logic signed [XW-1:0] y_w   [ITERATIONS+1];
  ang_t                 z_w   [ITERATIONS+1];

  assign busy = !rst_n;

  pthd_prep #(.CW(COORD_WIDTH), .XW(XW)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (start && !busy),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .ctl_o   (ctl_w[0]),
    .x_o     (x_w[0]),
    .y_o     (y_w[0]),
    .z_o     (z_w[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    pthd_cell #(.STAGE(i), .XW(XW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_w[i]),
      .x_i   (x_w[i]),
      .y_i   (y_w[i]),
      .z_i   (z_w[i]),
      .ctl_o (ctl_w[i+1]),
      .x_o   (x_w[i+1]),
      .y_o   (y_w[i+1]),
      .z_o   (z_w[i+1])
    );
  end

  pthd_post #(.XW(XW)) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_w[ITERATIONS]),
    .x_i       (x_w[ITERATIONS]),
    .z_i       (z_w[ITERATIONS]),
    .valid_o   (out_valid),
    .heading_o (out_heading),
    .dist_o    (out_distance)
  );

endmodule

### design/pthd_checker.sv
`include "point_heading_and_distance_defines.svh"

module pthd_checker #(
  parameter int ITERATIONS = 16
) (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input logic            out_valid,
  input pthd_pkg::head_t out_heading,
  input pthd_pkg::dist_t out_distance
);
  import pthd_pkg::*;

  localparam int LAT = ITERATIONS + 3;

  // every accepted transaction gives exactly one result a fixed time later
  `PTHD_ASSERT(a_accept_to_result, (start && !busy) |-> ##LAT out_valid, "result missing")
  `PTHD_ASSERT_IMP(a_result_has_source, out_valid, $past(start && !busy, LAT), "result invented")
  `PTHD_ASSERT_IMP(a_heading_range, out_valid,
                   (out_heading >= HEAD_MIN) && (out_heading <= HEAD_MAX), "heading range")
  // only the zero vector gives zero distance
  `PTHD_ASSERT_IMP(a_zero_dist, out_valid && (out_distance == '0), out_heading == '0,
                   "zero distance with heading")

endmodule

bind point_heading_and_distance pthd_checker #(.ITERATIONS(ITERATIONS)) u_pthd_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import pthd_pkg::*;

  localparam int ITER      = 16;
  localparam int CW        = 16;
  localparam int N_RANDOM  = 900;
  localparam int DRAIN_CYC = ITER + 12;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     gap;
  } pair_t;

  typedef struct {
    head_t heading;
    dist_t distance;
  } heading_dist_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   busy;
  logic   out_valid;
  head_t  out_heading;
  dist_t  out_distance;

  pair_t         pair_q[$];
  heading_dist_t expected_hd_q[$];
  pair_t         cur_pair;
  logic          in_taken = 1'b0;
  int            idle_left = 0;
  int            err_cnt = 0;
  bit            burst = 1'b0;

  // atan(2^-i), radians times 2^30
  longint atan_tbl [16] = '{
    843314857, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767
  };

  point_heading_and_distance #(
    .ITERATIONS  (ITER),
    .COORD_WIDTH (CW)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_end_x     (in_end_x),
    .in_end_y     (in_end_y),
    .out_valid    (out_valid),
    .out_heading  (out_heading),
    .out_distance (out_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic heading_dist_t calc_heading_distance(coord_t sx, coord_t sy,
                                                          coord_t ex, coord_t ey);
    longint dx, dy, x, y, z, xs, ys, hd;
    longint dst;
    heading_dist_t r;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    if (dy == 0) begin
      hd = (dx < 0) ? -25736 : 0;
      dst = (dx < 0) ? -dx : dx;
    end else if (dx == 0) begin
      hd = (dy > 0) ? 12868 : -12868;
      dst = (dy < 0) ? -dy : dy;
    end else begin
      // fold into the right half plane, start the angle at +/- pi
      if (dx < 0) begin
        x = -dx;
        y = -dy;
        z = (dy > 0) ? 64'sd3373259426 : -64'sd3373259426;
      end else begin
        x = dx;
        y = dy;
        z = 0;
      end
      x = x * 256;
      y = y * 256;
      for (int i = 0; i < ITER; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_tbl[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_tbl[i];
        end
      end
      hd = (z + 65536) >>> 17;
      if (hd < -25736) hd = -25736;
      if (hd > 25735) hd = 25735;
      if (dy > 0 && hd < 0) hd = 0;
      if (dy < 0 && hd > 0) hd = 0;
      if (x < 0) x = 0;
      dst = (x * 39797 + (64'sd1 << 23)) >>> 24;
    end
    if (dst > 131071) dst = 131071;
    r.heading  = hd[15:0];
    r.distance = dst[16:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic add_pair(int sx, int sy, int ex, int ey);
    pair_t p;
    p.sx = sx[CW-1:0];
    p.sy = sy[CW-1:0];
    p.ex = ex[CW-1:0];
    p.ey = ey[CW-1:0];
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    p.gap = burst ? 0 : $urandom_range(0, 3);
    pair_q.insert(pair_q.size(), p);
  endtask

  // driver: presents queued point pairs, with a random idle gap between transactions (none in bursts)
  always @(negedge clk) begin
    if (rst_n && (!start || in_taken)) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pair_q.size() > 0) begin
        cur_pair = pair_q.pop_front();
        in_start_x <= cur_pair.sx;
        in_start_y <= cur_pair.sy;
        in_end_x   <= cur_pair.ex;
        in_end_y   <= cur_pair.ey;
        idle_left  <= cur_pair.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: records accepted transactions and checks every strobed result
  always @(posedge clk) begin
    in_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      expected_hd_q.insert(expected_hd_q.size(),
                           calc_heading_distance(in_start_x, in_start_y,
                                                 in_end_x, in_end_y));
    if (rst_n && out_valid) begin
      if (expected_hd_q.size() == 0) begin
        flag_mismatch("unexpected result, heading", out_heading, 0);
      end else begin
        if (out_heading !== expected_hd_q[0].heading)
          flag_mismatch("heading", out_heading, expected_hd_q[0].heading);
        if (out_distance !== expected_hd_q[0].distance)
          flag_mismatch("distance", out_distance, expected_hd_q[0].distance);
        void'(expected_hd_q.pop_front());
      end
    end
  end

  initial begin
    int sx, sy, d;
    // equal points, zero vector
    add_pair(0, 0, 0, 0);
    add_pair(-32768, -32768, -32768, -32768);
    add_pair(32767, -32768, 32767, -32768);
    // horizontal and vertical lines
    add_pair(0, 0, 100, 0);
    add_pair(0, 5, -100, 5);
    add_pair(32767, 0, -32768, 0);
    add_pair(-32768, 7, 32767, 7);
    add_pair(3, 0, 3, 200);
    add_pair(3, 200, 3, 0);
    add_pair(0, -32768, 0, 32767);
    add_pair(0, 32767, 0, -32768);
    // full-scale diagonals in every quadrant
    add_pair(-32768, -32768, 32767, 32767);
    add_pair(32767, 32767, -32768, -32768);
    add_pair(32767, -32768, -32768, 32767);
    add_pair(-32768, 32767, 32767, -32768);
    // unit steps, both halves of the plane
    add_pair(0, 0, 1, 1);
    add_pair(0, 0, -1, 1);
    add_pair(0, 0, -1, -1);
    add_pair(0, 0, 1, -1);
    // nearly on the negative x axis and nearly vertical, heading clamps
    add_pair(32767, 0, -32768, 1);
    add_pair(32767, 0, -32768, -1);
    add_pair(0, -32768, 1, 32767);
    add_pair(0, 32767, -1, -32768);
    add_pair(0, 0, 1, 32767);
    for (int n = 0; n < N_RANDOM; n++) begin
      sx = $urandom_range(0, 65535) - 32768;
      sy = $urandom_range(0, 65535) - 32768;
      case ($urandom_range(0, 9))
        0: add_pair(sx, sy, sx, sy);
        1: add_pair(sx, sy, $urandom_range(0, 65535) - 32768, sy);
        2: add_pair(sx, sy, sx, $urandom_range(0, 65535) - 32768);
        3, 4: begin
          d = $urandom_range(0, 16) - 8;
          add_pair(sx, sy, sx + d, sy + $urandom_range(0, 16) - 8);
        end
        5: begin
          // shallow angle close to the x axis
          d = $urandom_range(0, 4) - 2;
          add_pair(sx, sy, $urandom_range(0, 65535) - 32768, sy + d);
        end
        default: add_pair(sx, sy, $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 65535) - 32768);
      endcase
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pair_q.size() > 0 || start) @(posedge clk);
    while (expected_hd_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0)
      $display("PASS point_heading_and_distance");
    else
      $display("FAIL point_heading_and_distance");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL point_heading_and_distance");
    $finish;
  end

endmodule
